// ===== rtl/core/sbgu_pkg.sv =====
// Package for the seven-bit group unpacker.
// Holds the group size, the sequencer state type and the result item type.
// No dependencies.
package sbgu_pkg;

	localparam int GroupSize = 7;
	localparam int FillW     = $clog2(GroupSize + 1);
	localparam int IdxW      = $clog2(GroupSize);
	localparam logic [7:0] HighBit = 8'h80;

	typedef enum logic {
		ST_COLLECT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       end_of_run;
	} out_item_t;

endpackage

// ===== rtl/core/sbgu_out_stage.sv =====
// Output register stage of the seven-bit group unpacker.
// Holds one result item and decouples the sequencer from the output handshake.
// Depends on sbgu_pkg.
module sbgu_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sbgu_pkg::out_item_t push_item,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output sbgu_pkg::out_item_t out_item
);

	logic                valid_q;
	sbgu_pkg::out_item_t item_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q <= push_item;
		end
	end

endmodule

// ===== rtl/core/seven_bit_group_unpacker_top.sv =====
// Seven-bit group unpacker: data bytes are held until their high-bits byte
// arrives, then the group is emitted one byte per cycle while the output
// register is free to take it. A high-bits byte (after seven data bytes, or
// the final byte) is followed by one result per pending byte, or by the
// empty end marker if none is pending, paced by the single output register
// and the emit counter; in_ready stays low while the group drains. Depends
// on sbgu_pkg and sbgu_out_stage.
module seven_bit_group_unpacker_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       is_final,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       end_of_run
);

	sbgu_pkg::state_t state_q, state_d;

	logic [7:0] pend_q [sbgu_pkg::GroupSize];
	logic [sbgu_pkg::FillW-1:0] fill_q;
	logic [sbgu_pkg::FillW-1:0] cnt_q;
	logic [sbgu_pkg::IdxW-1:0]  idx_q;
	logic [7:0] highs_q;
	logic       last_q;

	logic       accept;
	logic       start_emit;
	logic       push;
	logic       free;
	logic       emit_done;
	logic [sbgu_pkg::FillW-1:0] idx_ext;
	sbgu_pkg::out_item_t push_item;
	sbgu_pkg::out_item_t out_item;

	assign accept     = in_valid && in_ready;
	assign start_emit = accept &&
		(is_final || fill_q == sbgu_pkg::FillW'(sbgu_pkg::GroupSize));
	assign idx_ext    = sbgu_pkg::FillW'(idx_q);
	// empty marker when nothing pending, else stop on the last pending byte
	assign emit_done  = (cnt_q == '0) || (idx_ext == cnt_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbgu_pkg::ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		push      = 1'b0;
		push_item = '0;
		unique case (state_q)
			sbgu_pkg::ST_COLLECT: begin
				in_ready = 1'b1;
				if (start_emit) begin
					state_d = sbgu_pkg::ST_EMIT;
				end
			end
			sbgu_pkg::ST_EMIT: begin
				push = free;
				if (cnt_q == '0) begin
					push_item.out_byte   = '0;
					push_item.has_byte   = 1'b0;
					push_item.end_of_run = 1'b1;
				end else begin
					push_item.out_byte = pend_q[idx_q] |
						(highs_q[idx_q] ? sbgu_pkg::HighBit : 8'h00);
					push_item.has_byte   = 1'b1;
					push_item.end_of_run = last_q && emit_done;
				end
				if (free && emit_done) begin
					state_d = sbgu_pkg::ST_COLLECT;
				end
			end
			default: state_d = sbgu_pkg::ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q  <= '0;
		end else if (start_emit) begin
			fill_q <= '0;
			idx_q  <= '0;
		end else if (accept) begin
			fill_q <= fill_q + 1'b1;
		end else if (push && !emit_done) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start_emit) begin
			cnt_q   <= fill_q;
			highs_q <= in_byte;
			last_q  <= is_final;
		end else if (accept) begin
			pend_q[fill_q[sbgu_pkg::IdxW-1:0]] <= in_byte;
		end
	end

	sbgu_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	assign out_byte   = out_item.out_byte;
	assign has_byte   = out_item.has_byte;
	assign end_of_run = out_item.end_of_run;

endmodule

// ===== rtl/core/sbgu_checker.sv =====
// Port-level checks for the seven-bit group unpacker, with its bind.
// Sees only the ports of seven_bit_group_unpacker_top.
module sbgu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       is_final,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       has_byte,
	input logic       end_of_run
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(has_byte) && $stable(end_of_run))
		else $error("result changed while stalled");

	// an empty item is only ever the end marker
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> end_of_run && out_byte == 8'h00)
		else $error("empty item without end marker");

	// the final byte always produces at least one result, so input stalls
	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && is_final |=> !in_ready)
		else $error("input ready right after final byte");

	// a result is on the output after the final byte is taken
	a_final_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && is_final |=> ##1 out_valid)
		else $error("no result after final byte");

endmodule

bind seven_bit_group_unpacker_top sbgu_checker u_sbgu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.is_final   (is_final),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.has_byte   (has_byte),
	.end_of_run (end_of_run)
);
